// ----- rtl/core/sfd_pkg.sv -----
// Package for the sensor frame deframer: result word type, event codes,
// byte pattern constants and the result queue size. No dependencies.
package sfd_pkg;

  // Event codes carried in event_kind.
  localparam logic [1:0] EV_SAMPLE   = 2'd0;
  localparam logic [1:0] EV_BAD_HEAD = 2'd1;
  localparam logic [1:0] EV_INVALID  = 2'd2;
  localparam logic [1:0] EV_MISMATCH = 2'd3;

  // Head byte pattern: top three bits 101.
  localparam logic [7:0] HEAD_MASK  = 8'hE0;
  localparam logic [7:0] HEAD_MATCH = 8'hA0;

  // Result queue: four words, so a byte that causes two results can be
  // taken while up to two older words still wait.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned PTR_W       = 2;
  localparam int unsigned CNT_W       = 3;

  // One result word as it leaves the block.
  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] port;
    logic [9:0] value;
    logic       adc;
    logic       changed;
    logic       last;
  } result_t;

  // Words produced by one input byte: how many (0 to 2) and the words.
  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

// ----- rtl/core/sensor_frame_deframer_top.sv -----
// Top level of the sensor frame deframer: input byte register, frame parser
// and result queue. Depends on sfd_pkg, sfd_parse and sfd_outq.
//
// Usage: serial bytes enter on in_valid/in_ready/in_byte, one word each.
// Each byte yields zero, one or two result words on out_valid/out_ready,
// carrying event_kind, port_id, sample_value, adc_slow, adc_changed and
// last_of_run; last_of_run marks the final word caused by a byte.
// A byte is first held in an input register; once the queue has room it
// is parsed and its words are written to a four-word queue, whose head
// word drives the output port.
// Throughput: one byte per cycle while the queue holds two words or fewer
// at the moment of parsing; since words leave at one per cycle while
// out_ready is high, the sustained rate is the output's, one word per cycle.
// Reset (rst, synchronous) empties the register and queue and puts the
// parser in head search with expected port zero and no ADC history.
// When the receiver stalls, words pile up in the queue; once it holds more
// than two, parsing pauses and in_ready drops after the input register fills.
module sensor_frame_deframer_top #(
  parameter int unsigned NUM_PORTS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] event_kind,
  output logic [3:0] port_id,
  output logic [9:0] sample_value,
  output logic       adc_slow,
  output logic       adc_changed,
  output logic       last_of_run
);

  logic             byte_valid;
  logic [7:0]       byte_reg;
  logic             take;
  logic             room;
  sfd_pkg::push_t   push;
  sfd_pkg::result_t head;

  // The held byte is parsed whenever the queue can take two words.
  assign take     = byte_valid && room;
  assign in_ready = !byte_valid || take;

  // Input byte register.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (in_ready) begin
      byte_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_reg <= in_byte;
    end
  end

  sfd_parse #(
    .NUM_PORTS (NUM_PORTS)
  ) u_parse (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .item_byte (byte_reg),
    .push      (push)
  );

  sfd_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop_ready (out_ready),
    .pop_valid (out_valid),
    .head      (head),
    .room      (room)
  );

  // Result word fields.
  assign event_kind   = head.kind;
  assign port_id      = head.port;
  assign sample_value = head.value;
  assign adc_slow     = head.adc;
  assign adc_changed  = head.changed;
  assign last_of_run  = head.last;

endmodule

// ----- rtl/core/sfd_parse.sv -----
// Frame parser: holds the framing and round-robin state and turns one byte
// into up to two result words. Depends on sfd_pkg.
module sfd_parse #(
  parameter int unsigned NUM_PORTS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          take,
  input  logic [7:0]    item_byte,
  output sfd_pkg::push_t push
);

  localparam logic [1:0] PH_HUNT = 2'd0;
  localparam logic [1:0] PH_HIGH = 2'd1;
  localparam logic [1:0] PH_LOW  = 2'd2;
  localparam logic [3:0] LAST_PORT = 4'(NUM_PORTS - 1);

  logic [1:0] phase, phase_next;
  logic [3:0] frame_port, frame_port_next;
  logic       frame_adc, frame_adc_next;
  logic [6:0] high_part, high_part_next;
  logic [3:0] expected_port, expected_port_next;
  logic       adc_known, adc_known_next;
  logic       adc_previous, adc_previous_next;

  logic          hunt;
  logic [1:0]    cnt;
  sfd_pkg::result_t r0, r1, bad;

  // Decode of one byte against the current phase.
  always_comb begin
    phase_next         = phase;
    frame_port_next    = frame_port;
    frame_adc_next     = frame_adc;
    high_part_next     = high_part;
    expected_port_next = expected_port;
    adc_known_next     = adc_known;
    adc_previous_next  = adc_previous;
    hunt = 1'b1;
    cnt  = 2'd0;
    r0   = '0;
    r1   = '0;
    bad  = '0;
    bad.kind = sfd_pkg::EV_BAD_HEAD;

    unique case (phase)
      PH_HIGH, PH_LOW: begin
        if (item_byte[7]) begin
          // Part byte that looks like a head: drop the frame, then rescan.
          r0.kind    = sfd_pkg::EV_INVALID;
          cnt        = 2'd1;
          phase_next = PH_HUNT;
        end else if (phase == PH_HIGH) begin
          high_part_next = item_byte[6:0];
          phase_next     = PH_LOW;
          hunt           = 1'b0;
        end else begin
          phase_next = PH_HUNT;
          hunt       = 1'b0;
          cnt        = 2'd1;
          if (high_part[3:0] != item_byte[6:3]) begin
            r0.kind = sfd_pkg::EV_INVALID;
          end else if (frame_port != expected_port) begin
            r0.kind = sfd_pkg::EV_MISMATCH;
            r0.port = frame_port;
            r0.adc  = frame_adc;
          end else begin
            r0.kind    = sfd_pkg::EV_SAMPLE;
            r0.port    = frame_port;
            r0.value   = {high_part, 3'b000} | {3'b000, item_byte[6:0]};
            r0.adc     = frame_adc;
            r0.changed = !adc_known || (adc_previous != frame_adc);
            expected_port_next = (expected_port == LAST_PORT) ? 4'd0
                                                              : expected_port + 4'd1;
            adc_known_next    = 1'b1;
            adc_previous_next = frame_adc;
          end
        end
      end
      default: begin
      end
    endcase

    // Head search, also for a part byte that had bit 7 set.
    if (hunt) begin
      if ((item_byte & sfd_pkg::HEAD_MASK) == sfd_pkg::HEAD_MATCH) begin
        frame_adc_next  = item_byte[4];
        frame_port_next = item_byte[3:0];
        phase_next      = PH_HIGH;
      end else begin
        phase_next = PH_HUNT;
        if (cnt == 2'd0) begin
          r0 = bad;
        end else begin
          r1 = bad;
        end
        cnt = cnt + 2'd1;
      end
    end

    // Mark the final word of this byte.
    if (cnt == 2'd1) begin
      r0.last = 1'b1;
    end
    if (cnt == 2'd2) begin
      r1.last = 1'b1;
    end
  end

  assign push.cnt = take ? cnt : 2'd0;
  assign push.r0  = r0;
  assign push.r1  = r1;

  // State registers advance only when a byte is consumed.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      frame_port    <= '0;
      frame_adc     <= 1'b0;
      high_part     <= '0;
      expected_port <= '0;
      adc_known     <= 1'b0;
      adc_previous  <= 1'b0;
    end else if (take) begin
      phase         <= phase_next;
      frame_port    <= frame_port_next;
      frame_adc     <= frame_adc_next;
      high_part     <= high_part_next;
      expected_port <= expected_port_next;
      adc_known     <= adc_known_next;
      adc_previous  <= adc_previous_next;
    end
  end

  // The expected port always stays inside the round-robin range.
  a_exp_range: assert property (@(posedge clk) disable iff (rst)
    expected_port <= LAST_PORT)
    else $error("expected port out of range");

  // Two words from one byte are only ever a dropped frame then a bad head.
  a_two_words: assert property (@(posedge clk) disable iff (rst)
    (push.cnt == 2'd2) |-> (push.r0.kind == sfd_pkg::EV_INVALID &&
                            push.r1.kind == sfd_pkg::EV_BAD_HEAD))
    else $error("unexpected pair of result words");

  // A clean high part always moves the parser on to the low part.
  a_high_to_low: assert property (@(posedge clk) disable iff (rst)
    (take && phase == PH_HIGH && !item_byte[7]) |=> (phase == PH_LOW))
    else $error("high part did not advance the phase");

endmodule

// ----- rtl/core/sfd_outq.sv -----
// Result queue: four-word buffer that takes up to two words a cycle and
// hands out one while pop_ready is high. Depends on sfd_pkg.
module sfd_outq (
  input  logic             clk,
  input  logic             rst,
  input  sfd_pkg::push_t   push,
  input  logic             pop_ready,
  output logic             pop_valid,
  output sfd_pkg::result_t head,
  output logic             room
);

  sfd_pkg::result_t mem [sfd_pkg::QUEUE_DEPTH];
  logic [sfd_pkg::PTR_W-1:0] wr_ptr, rd_ptr;
  logic [sfd_pkg::CNT_W-1:0] count;
  logic                      pop;

  assign pop_valid = (count != '0);
  assign pop       = pop_valid && pop_ready;
  assign head      = mem[rd_ptr];
  // Room for a full pair of words, whatever is popped this cycle.
  assign room      = (count <= sfd_pkg::CNT_W'(sfd_pkg::QUEUE_DEPTH - 2));

  // Storage writes.
  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem[wr_ptr] <= push.r0;
    end
    if (push.cnt == 2'd2) begin
      mem[wr_ptr + sfd_pkg::PTR_W'(1)] <= push.r1;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + sfd_pkg::PTR_W'(push.cnt);
      if (pop) begin
        rd_ptr <= rd_ptr + sfd_pkg::PTR_W'(1);
      end
      count <= count + sfd_pkg::CNT_W'(push.cnt) - sfd_pkg::CNT_W'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= sfd_pkg::CNT_W'(sfd_pkg::QUEUE_DEPTH))
    else $error("result queue overfilled");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (push.cnt != 2'd0) |-> room)
    else $error("words pushed without room");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    (count == sfd_pkg::CNT_W'(1) && pop && push.cnt == 2'd0) |=> !pop_valid)
    else $error("queue did not empty after last pop");

endmodule
